// ===== hw/rtl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the gated spectrum accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package gsa_pkg;

  localparam int TimeW  = 48;
  localparam int LiveW  = 49;
  localparam int BinW   = 32;
  localparam int LenW   = 30;   // analog_blocks (8 bits) shifted by up to 22
  localparam int CfgIdxW = 2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_BOARD = 2'd1;
  localparam logic [1:0] STATUS_ZERO_BLK  = 2'd2;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_WIN_START = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIN_END   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DT_CORR   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TICK_LEN  = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [1:0]        status;
    logic [1:0]        board;
    logic [5:0]        channel;
    logic [15:0]       count;
    logic [TimeW-1:0]  event_time;
    logic [2:0]        integ_mode;
    logic [7:0]        analog_blocks;
    logic [7:0]        digital_blocks;
    logic [15:0]       dead_time_count;
    logic              chan_ok;    // channel addresses a real bin
    logic              last_chan;  // overflow channel, ends the record
  } job_t;

  typedef struct packed {
    logic [TimeW-1:0] window_start;
    logic [TimeW-1:0] window_end;
    logic             dead_time_correct;
    logic [31:0]      dead_tick_length;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MID,
    ST_UPD,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gsa_ram.sv =====
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 220
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gsa_queue.sv =====
// ----------------------------------------------------------------------------
// gsa_queue
// Short FIFO of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module gsa_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire gsa_pkg::job_t push_job,
  input  wire logic          pop,
  output gsa_pkg::job_t      head,
  output logic               empty,
  output logic               full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gsa_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign empty = (fill == '0);
  assign full  = (fill == (PW+1)'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gsa_front.sv =====
// ----------------------------------------------------------------------------
// gsa_front
// Accepts input words, checks board and block count, and queues a job.
// ----------------------------------------------------------------------------
`default_nettype none
module gsa_front #(
  parameter int BOARD_COUNT = 4,
  parameter int ENERGY_BINS = 54
) (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [111:0]  s_tdata,
  input  wire logic          s_tuser,
  input  wire logic          q_full,
  output logic               push,
  output gsa_pkg::job_t      push_job
);

  logic [1:0] header_board;
  logic       board_bad;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_job                 = '0;
    push_job.opcode          = s_tuser;
    push_job.board           = s_tdata[1:0];
    header_board             = s_tdata[3:2];
    push_job.channel         = s_tdata[9:4];
    push_job.count           = s_tdata[25:10];
    push_job.event_time      = s_tdata[73:26];
    push_job.integ_mode      = s_tdata[76:74];
    push_job.analog_blocks   = s_tdata[84:77];
    push_job.digital_blocks  = s_tdata[92:85];
    push_job.dead_time_count = s_tdata[108:93];
    push_job.chan_ok   = (9'(push_job.channel) < 9'(ENERGY_BINS + 1));
    push_job.last_chan = (9'(push_job.channel) == 9'(ENERGY_BINS));
    board_bad = (5'(push_job.board) >= 5'(BOARD_COUNT));
    if (push_job.opcode == gsa_pkg::OP_READ) begin
      push_job.status = board_bad ? gsa_pkg::STATUS_BAD_BOARD : gsa_pkg::STATUS_OK;
    end else if (board_bad || (push_job.board != header_board)) begin
      push_job.status = gsa_pkg::STATUS_BAD_BOARD;
    end else if (push_job.digital_blocks == 8'd0) begin
      push_job.status = gsa_pkg::STATUS_ZERO_BLK;
    end else begin
      push_job.status = gsa_pkg::STATUS_OK;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gsa_back.sv =====
// ----------------------------------------------------------------------------
// gsa_back
// Executes jobs: bin length divide, window test, spectrum read-modify-write,
// per-board time sums, and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none
module gsa_back #(
  parameter int BOARD_COUNT = 4,
  parameter int ENERGY_BINS = 54
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gsa_pkg::cfg_t cfg,
  input  wire gsa_pkg::job_t head,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [231:0]       m_tdata,
  output logic [1:0]         m_tuser
);

  localparam int CHANS = ENERGY_BINS + 1;
  localparam int DEPTH = BOARD_COUNT * CHANS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
  localparam int TW    = gsa_pkg::TimeW;
  localparam int LW    = gsa_pkg::LenW;

  localparam logic signed [50:0] LIVE_MAX = 51'sd281474976710655;
  localparam logic signed [50:0] LIVE_MIN = -51'sd281474976710656;

  gsa_pkg::state_t state, state_next;
  gsa_pkg::job_t   job;

  // per-board state
  logic                    board_seen    [BOARD_COUNT];
  logic [15:0]             prev_dead     [BOARD_COUNT];
  logic [TW-1:0]           on_sum        [BOARD_COUNT];
  logic signed [48:0]      live_sum      [BOARD_COUNT];
  logic [TW-1:0]           start_stamp   [BOARD_COUNT];
  logic [TW-1:0]           stop_stamp    [BOARD_COUNT];
  logic                    start_pending [BOARD_COUNT];
  logic                    stop_pending  [BOARD_COUNT];

  logic [DEPTH-1:0]  filled;
  logic [AW-1:0]     head_addr;
  logic [AW-1:0]     addr;
  logic [31:0]       ram_rdata;
  logic [31:0]       bin;
  logic [31:0]       bin_sum_sat;
  logic [32:0]       bin_sum;
  logic              ram_we;

  logic [BW-1:0]     bidx;
  logic [BW-1:0]     head_bidx;

  logic [LW-1:0]     num;
  logic [7:0]        rem;
  logic [LW-1:0]     len;
  logic [4:0]        div_cnt;
  logic [8:0]        trial;
  logic              trial_ge;

  logic [15:0]       delta;
  logic [31:0]       dead;
  logic signed [50:0] mid2;
  logic signed [50:0] ev_start;

  logic              in_window;
  logic              past;
  logic [TW:0]       on_add;
  logic [TW-1:0]     on_new;
  logic signed [50:0] live_add;
  logic signed [48:0] live_new;
  logic [TW-1:0]     start_val;

  logic              load_out;
  logic              out_free;

  assign head_bidx = BW'(head.board);
  assign bidx      = BW'(job.board);
  assign head_addr = AW'(int'(head_bidx) * CHANS + int'(head.channel));
  assign out_free  = !m_tvalid || m_tready;

  gsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_spectrum (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (bin_sum_sat),
    .raddr (head_addr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gsa_pkg::ST_IDLE: if (!q_empty) state_next = gsa_pkg::ST_READ;
      gsa_pkg::ST_READ: begin
        if (job.opcode == gsa_pkg::OP_ACCUM && job.status == gsa_pkg::STATUS_OK &&
            job.chan_ok) begin
          state_next = gsa_pkg::ST_DIV;
        end else begin
          state_next = gsa_pkg::ST_RESP;
        end
      end
      gsa_pkg::ST_DIV:  if (div_cnt == 5'd0) state_next = gsa_pkg::ST_MID;
      gsa_pkg::ST_MID:  state_next = gsa_pkg::ST_UPD;
      gsa_pkg::ST_UPD:  state_next = gsa_pkg::ST_RESP;
      gsa_pkg::ST_RESP: if (out_free) state_next = gsa_pkg::ST_IDLE;
      default:          state_next = gsa_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      gsa_pkg::ST_IDLE: pop      = !q_empty;
      gsa_pkg::ST_UPD:  ram_we   = board_seen[bidx] && in_window;
      gsa_pkg::ST_RESP: load_out = out_free;
      default: ;
    endcase
  end

  // datapath arithmetic
  always_comb begin
    trial    = {rem, num[LW-1]};
    trial_ge = (trial >= {1'b0, job.digital_blocks});
    bin_sum  = {1'b0, bin} + 33'(job.count);
    bin_sum_sat = bin_sum[32] ? 32'hFFFF_FFFF : bin_sum[31:0];
    in_window = (mid2 > $signed({2'b00, cfg.window_start, 1'b0})) &&
                (mid2 < $signed({2'b00, cfg.window_end, 1'b0}));
    past   = (mid2 >= $signed({2'b00, cfg.window_end, 1'b0}));
    on_add = {1'b0, on_sum[bidx]} + (TW+1)'(len);
    on_new = on_add[TW] ? {TW{1'b1}} : on_add[TW-1:0];
    live_add = 51'(live_sum[bidx]) + $signed({21'b0, len}) - $signed({19'b0, dead});
    if (live_add > LIVE_MAX) begin
      live_new = 49'(LIVE_MAX);
    end else if (live_add < LIVE_MIN) begin
      live_new = 49'(LIVE_MIN);
    end else begin
      live_new = live_add[48:0];
    end
    start_val = ev_start[50] ? '0 : ev_start[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // job and arithmetic registers
  always_ff @(posedge clk) begin
    case (state)
      gsa_pkg::ST_IDLE: begin
        job  <= head;
        addr <= head_addr;
      end
      gsa_pkg::ST_READ: begin
        bin     <= (job.chan_ok && filled[addr]) ? ram_rdata : 32'd0;
        num     <= LW'({22'b0, job.analog_blocks} << (5'(job.integ_mode) + 5'd15));
        rem     <= '0;
        len     <= '0;
        div_cnt <= 5'(LW - 1);
        delta   <= job.dead_time_count - prev_dead[bidx];
      end
      gsa_pkg::ST_DIV: begin
        num     <= {num[LW-2:0], 1'b0};
        rem     <= trial_ge ? 8'(trial - {1'b0, job.digital_blocks}) : trial[7:0];
        len     <= {len[LW-2:0], trial_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      gsa_pkg::ST_MID: begin
        mid2     <= $signed({2'b00, job.event_time, 1'b0}) - $signed({21'b0, len});
        ev_start <= $signed({3'b000, job.event_time}) - $signed({21'b0, len});
        dead     <= 32'((48'(delta) * 48'(cfg.dead_tick_length)) >> 16);
      end
      gsa_pkg::ST_UPD: begin
        if (ram_we) begin
          bin <= bin_sum_sat;
        end
      end
      default: ;
    endcase
  end

  // per-board state and spectrum fill marks
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      for (int b = 0; b < BOARD_COUNT; b++) begin
        board_seen[b]    <= 1'b0;
        prev_dead[b]     <= '0;
        on_sum[b]        <= '0;
        live_sum[b]      <= '0;
        start_stamp[b]   <= '0;
        stop_stamp[b]    <= '0;
        start_pending[b] <= 1'b1;
        stop_pending[b]  <= 1'b1;
      end
    end else if (state == gsa_pkg::ST_UPD) begin
      if (ram_we) begin
        filled[addr] <= 1'b1;
      end
      if (job.last_chan) begin
        prev_dead[bidx] <= job.dead_time_count;
        if (!board_seen[bidx]) begin
          board_seen[bidx] <= 1'b1;
        end else if (in_window) begin
          if (start_pending[bidx]) begin
            start_stamp[bidx]   <= start_val;
            start_pending[bidx] <= 1'b0;
          end
          on_sum[bidx]   <= on_new;
          live_sum[bidx] <= cfg.dead_time_correct ? live_new : $signed({1'b0, on_new});
        end else if (past && stop_pending[bidx]) begin
          stop_stamp[bidx]   <= start_val;
          stop_pending[bidx] <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= job.status;
      if (job.status != gsa_pkg::STATUS_OK) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {7'b0, stop_stamp[bidx], start_stamp[bidx], live_sum[bidx],
                    on_sum[bidx], bin};
      end
    end
  end

  ast_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != gsa_pkg::STATUS_OK |-> m_tdata == '0)
    else $error("dropped word carries payload");

  ast_div_end: assert property (@(posedge clk) disable iff (rst)
    state == gsa_pkg::ST_DIV && div_cnt == 5'd0 |=> state == gsa_pkg::ST_MID)
    else $error("divider overran its step count");

  ast_we_upd: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == gsa_pkg::ST_UPD && job.status == gsa_pkg::STATUS_OK)
    else $error("spectrum written outside update");

endmodule
`default_nettype wire

// ===== hw/rtl/gated_spectrum_accumulator.sv =====
// Reads, drops and out-of-range channels go from acceptance through the IDLE,
// READ and RESP states to m_tvalid; an accumulate item also passes through the
// 30-step bit-serial bin length divider (DIV), then MID and UPD. One item is
// worked on at a time, and an m_tready stall holds the result word in RESP;
// a 2-entry queue takes new words while the back end works. Synchronous
// active-high reset clears the spectrum (via per-entry fill marks) and board state, and resets config to its defaults.
// ----------------------------------------------------------------------------
// gated_spectrum_accumulator
// Per-board pulse-height spectrum builder with a time window gate, on-time and
// live-time sums, and start/stop time latches.
// ----------------------------------------------------------------------------
`default_nettype none
module gated_spectrum_accumulator #(
  parameter int BOARD_COUNT = 4,
  parameter int ENERGY_BINS = 54
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input words. tdata from bit 0: board[1:0], header_board[3:2],
  // channel[9:4], count[25:10], event_time[73:26], integ_mode[76:74],
  // analog_blocks[84:77], digital_blocks[92:85], dead_time_count[108:93].
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic         s_tuser,   // opcode
  // Result words. tdata from bit 0: bin_total[31:0], on_time[79:32],
  // live_time[128:80], start_time[176:129], stop_time[224:177].
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [231:0]      m_tdata,
  output logic [1:0]        m_tuser,   // status
  // Configuration writes.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);

  gsa_pkg::cfg_t cfg;
  gsa_pkg::job_t push_job;
  gsa_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  // Configuration is always accepted; the host must write it only while no word
  // is in flight, and the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_start      <= '0;
      cfg.window_end        <= '1;
      cfg.dead_time_correct <= 1'b1;
      cfg.dead_tick_length  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gsa_pkg::REG_WIN_START: cfg.window_start      <= cfg_data;
        gsa_pkg::REG_WIN_END:   cfg.window_end        <= cfg_data;
        gsa_pkg::REG_DT_CORR:   cfg.dead_time_correct <= cfg_data[0];
        gsa_pkg::REG_TICK_LEN:  cfg.dead_tick_length  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each word and queue it.
  gsa_front #(.BOARD_COUNT(BOARD_COUNT), .ENERGY_BINS(ENERGY_BINS)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  gsa_queue #(.DEPTH(2)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end: divide, gate, update the spectrum and time sums, then respond.
  gsa_back #(.BOARD_COUNT(BOARD_COUNT), .ENERGY_BINS(ENERGY_BINS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_gated_spectrum_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_gated_spectrum_accumulator
// Self-checking bench for the gated spectrum accumulator. A directed table of
// words covers drops, reads, priming, extremes and wrap; six random phases of
// records per board, mixed with noise words, follow. Every result word is
// compared with a fixed expectation or an in-bench model of the spectrum, time sums and start/stop latches.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_gated_spectrum_accumulator;

  localparam int NB = 4;
  localparam int NCH = 55;   // energy bins plus the overflow channel
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  board;
    logic [1:0]  header_board;
    logic [5:0]  channel;
    logic [15:0] count;
    logic [47:0] event_time;
    logic [2:0]  integ_mode;
    logic [7:0]  analog_blocks;
    logic [7:0]  digital_blocks;
    logic [15:0] dead_time_count;
  } word_t;

  localparam int WORD_W = $bits(word_t);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] bin_total;
    logic [47:0] on_time;
    logic [48:0] live_time;
    logic [47:0] start_time;
    logic [47:0] stop_time;
  } res_t;

  // A directed row: the word, and a fixed expectation where one is given.
  typedef struct {
    word_t w;
    bit    fixed;
    res_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [231:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  always #5 clk = ~clk;

  gated_spectrum_accumulator uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Model state: configuration plus one copy of each board's sums.
  logic [47:0] win_lo, win_hi;
  logic        dt_on;
  logic [31:0] tick_len;
  logic [31:0] spec [NB*NCH];
  bit          seen [NB];
  logic [15:0] last_dtc [NB];
  logic [47:0] on_acc [NB];
  longint      live_acc [NB];
  logic [47:0] t_start [NB], t_stop [NB];
  bit          start_open [NB], stop_open [NB];

  res_t pending_results[$];
  int   errors = 0;

  function automatic logic [47:0] stamp(longint v);
    return v < 0 ? 48'd0 : v[47:0];
  endfunction

  function automatic res_t report(int b, int ch);
    res_t r;
    r.status     = gsa_pkg::STATUS_OK;
    r.bin_total  = ch < NCH ? spec[b*NCH+ch] : 32'd0;
    r.on_time    = on_acc[b];
    r.live_time  = live_acc[b][48:0];
    r.start_time = t_start[b];
    r.stop_time  = t_stop[b];
    return r;
  endfunction

  // Applies one word to the model and returns the result it should produce.
  function automatic res_t accumulate(word_t w);
    res_t r;
    int b, ch;
    longint len, mid2, ev, dead, lv;
    logic [63:0] delta, on;
    bit in_win, past;
    r = '0;
    b = int'(w.board);
    ch = int'(w.channel);
    if (w.opcode == gsa_pkg::OP_READ) return report(b, ch);
    if (w.board != w.header_board) begin
      r.status = gsa_pkg::STATUS_BAD_BOARD;
      return r;
    end
    if (w.digital_blocks == 8'd0) begin
      r.status = gsa_pkg::STATUS_ZERO_BLK;
      return r;
    end
    if (ch >= NCH) return report(b, NCH);
    ev = longint'(w.event_time);
    len = longint'((64'(w.analog_blocks) << (w.integ_mode + 15)) / 64'(w.digital_blocks));
    mid2 = 2*ev - len;
    in_win = mid2 > 2*longint'(win_lo) && mid2 < 2*longint'(win_hi);
    past = mid2 >= 2*longint'(win_hi);
    if (seen[b] && in_win) begin
      on = 64'(spec[b*NCH+ch]) + 64'(w.count);
      spec[b*NCH+ch] = on > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : on[31:0];
    end
    if (ch == NCH-1) begin
      if (!seen[b]) begin
        last_dtc[b] = w.dead_time_count;
        seen[b] = 1'b1;
      end else begin
        delta = 64'(16'(w.dead_time_count - last_dtc[b]));
        last_dtc[b] = w.dead_time_count;
        if (in_win) begin
          if (start_open[b]) begin
            t_start[b] = stamp(ev - len);
            start_open[b] = 1'b0;
          end
          on = 64'(on_acc[b]) + 64'(len);
          on_acc[b] = on > 64'(T_MAX) ? T_MAX : on[47:0];
          if (dt_on) begin
            dead = longint'((delta * 64'(tick_len)) >> 16);
            lv = live_acc[b] + len - dead;
            if (lv > longint'(T_MAX)) lv = longint'(T_MAX);
            if (lv < -longint'(64'h1_0000_0000_0000)) lv = -longint'(64'h1_0000_0000_0000);
            live_acc[b] = lv;
          end else begin
            live_acc[b] = longint'(on_acc[b]);
          end
        end else if (past && stop_open[b]) begin
          t_stop[b] = stamp(ev - len);
          stop_open[b] = 1'b0;
        end
      end
    end
    return report(b, ch);
  endfunction

  // Receiver: stalls in a randomly chosen pattern, occasionally fully open.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= int'($urandom_range(0, 3));
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= $urandom_range(0, 7) == 0;
        default: m_tready <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  // Checker: each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    res_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = m_tuser;
      got.bin_total  = m_tdata[31:0];
      got.on_time    = m_tdata[79:32];
      got.live_time  = m_tdata[128:80];
      got.start_time = m_tdata[176:129];
      got.stop_time  = m_tdata[224:177];
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.bin_total !== exp_r.bin_total) begin
          $error("bin_total exp %0d got %0d", exp_r.bin_total, got.bin_total); errors++;
        end
        if (got.on_time !== exp_r.on_time) begin
          $error("on_time exp %0d got %0d", exp_r.on_time, got.on_time); errors++;
        end
        if (got.live_time !== exp_r.live_time) begin
          $error("live_time exp %h got %h", exp_r.live_time, got.live_time); errors++;
        end
        if (got.start_time !== exp_r.start_time) begin
          $error("start_time exp %0d got %0d", exp_r.start_time, got.start_time); errors++;
        end
        if (got.stop_time !== exp_r.stop_time) begin
          $error("stop_time exp %0d got %0d", exp_r.stop_time, got.stop_time); errors++;
        end
      end
    end
  end

  // Sender: burst of words, then a random gap. The valid stays high across
  // back-to-back words so it is never dropped and raised in one step.
  int burst_left = 0;
  task automatic send_word(word_t w, res_t r);
    while (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = int'($urandom_range(1, 20));
    end
    s_tuser <= w.opcode;
    s_tdata <= {3'b0, w.dead_time_count, w.digital_blocks, w.analog_blocks, w.integ_mode,
                w.event_time, w.count, w.channel, w.header_board, w.board};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(r);
    burst_left--;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      gsa_pkg::REG_WIN_START: win_lo = val;
      gsa_pkg::REG_WIN_END:   win_hi = val;
      gsa_pkg::REG_DT_CORR:   dt_on = val[0];
      default:                tick_len = val[31:0];
    endcase
  endtask

  // Waits until the results are all back and the block has gone quiet.
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic word_t rec(int b, int ch, logic [15:0] cnt, logic [47:0] ev,
                                logic [2:0] md, logic [7:0] ab, logic [7:0] db,
                                logic [15:0] dtc);
    word_t w;
    w.opcode = gsa_pkg::OP_ACCUM; w.board = 2'(b); w.header_board = 2'(b);
    w.channel = 6'(ch);
    w.count = cnt; w.event_time = ev; w.integ_mode = md; w.analog_blocks = ab;
    w.digital_blocks = db; w.dead_time_count = dtc;
    return w;
  endfunction

  function automatic word_t rd(int b, int ch);
    word_t w;
    w = '0;
    w.opcode = gsa_pkg::OP_READ; w.board = 2'(b); w.channel = 6'(ch);
    return w;
  endfunction

  // Sends a whole record (a few channels, then overflow) of board b.
  task automatic send_record(int b, logic [47:0] ev, logic [2:0] md, logic [7:0] ab,
                             logic [7:0] db, logic [15:0] dtc);
    int n;
    word_t w;
    n = int'($urandom_range(0, 4));
    repeat (n) begin
      w = rec(b, int'($urandom_range(0, NCH-2)),
              $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom), ev, md, ab, db, dtc);
      send_word(w, accumulate(w));
    end
    w = rec(b, NCH-1, 16'($urandom), ev, md, ab, db, dtc);
    send_word(w, accumulate(w));
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    #2_000_000_000;
    $display("gated_spectrum_accumulator test failed");
    $finish;
  end

  initial begin
    row_t tbl[$];
    row_t rw;
    word_t w;
    res_t r, zero_r;
    int b;
    logic [47:0] ev;
    win_lo = '0; win_hi = T_MAX; dt_on = 1'b1; tick_len = '0;
    for (int i = 0; i < NB*NCH; i++) spec[i] = '0;
    for (int i = 0; i < NB; i++) begin
      seen[i] = 1'b0; last_dtc[i] = '0; on_acc[i] = '0; live_acc[i] = 0;
      t_start[i] = '0; t_stop[i] = '0; start_open[i] = 1'b1; stop_open[i] = 1'b1;
    end
    zero_r = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows. Fixed expectations: fresh reads, drops.
    rw.fixed = 1'b1; rw.r = zero_r;
    rw.w = rd(0, 0); tbl.push_back(rw);
    rw.w = rd(3, 54); tbl.push_back(rw);
    rw.w = rec(1, 3, 16'hFFFF, T_MAX, 3'd7, 8'hFF, 8'hFF, 16'hFFFF);
    rw.w.header_board = 2'd2; rw.r.status = gsa_pkg::STATUS_BAD_BOARD; tbl.push_back(rw);
    rw.w = rec(2, 3, 16'd5, T_MAX, 3'd0, 8'd1, 8'd0, 16'd0);
    rw.r.status = gsa_pkg::STATUS_ZERO_BLK; tbl.push_back(rw);
    rw.fixed = 1'b0;
    // Out-of-range channel, then priming, then real records with counter wrap.
    rw.w = rec(0, 63, 16'd1, 48'd1000000, 3'd1, 8'd1, 8'd1, 16'd0); tbl.push_back(rw);
    rw.w = rec(0, 5, 16'd7, 48'd1000000, 3'd1, 8'd1, 8'd1, 16'hFFF0); tbl.push_back(rw);
    rw.w = rec(0, 54, 16'd7, 48'd1000000, 3'd1, 8'd1, 8'd1, 16'hFFF0); tbl.push_back(rw);
    rw.w = rec(0, 5, 16'hFFFF, 48'd2000000, 3'd7, 8'hFF, 8'd1, 16'h0010); tbl.push_back(rw);
    rw.w = rec(0, 0, 16'hFFFF, 48'd2000000, 3'd7, 8'hFF, 8'd1, 16'h0010); tbl.push_back(rw);
    rw.w = rec(0, 54, 16'hFFFF, 48'd2000000, 3'd7, 8'hFF, 8'd1, 16'h0010); tbl.push_back(rw);
    // Tiny event time: midpoint negative, then a start stamp that clamps at zero.
    rw.w = rec(1, 54, 16'd0, 48'd0, 3'd0, 8'd1, 8'd255, 16'd0); tbl.push_back(rw);
    rw.w = rec(1, 54, 16'd0, 48'd10, 3'd0, 8'd255, 8'd3, 16'd9); tbl.push_back(rw);
    rw.w = rec(1, 54, 16'd0, 48'd2000000, 3'd0, 8'd255, 8'd3, 16'd20); tbl.push_back(rw);
    rw.w = rec(1, 54, 16'd0, T_MAX, 3'd7, 8'd255, 8'd255, 16'd0); tbl.push_back(rw);
    rw.w = rd(0, 5); tbl.push_back(rw);
    rw.w = rd(1, 63); tbl.push_back(rw);
    foreach (tbl[i]) begin
      r = accumulate(tbl[i].w);
      if (tbl[i].fixed) r = tbl[i].r;
      send_word(tbl[i].w, r);
    end
    drain();

    // Random phases, each under its own register setting, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(gsa_pkg::REG_WIN_START, 48'd0); write_reg(gsa_pkg::REG_WIN_END, T_MAX);
          write_reg(gsa_pkg::REG_DT_CORR, 48'd1);
          write_reg(gsa_pkg::REG_TICK_LEN, 48'hFFFF_FFFF);
        end
        1: begin
          write_reg(gsa_pkg::REG_WIN_START, 48'h0000_4000_0000);
          write_reg(gsa_pkg::REG_WIN_END, 48'h0000_C000_0000);
          write_reg(gsa_pkg::REG_DT_CORR, 48'd0); write_reg(gsa_pkg::REG_TICK_LEN, 48'd0);
        end
        2: begin
          write_reg(gsa_pkg::REG_WIN_START, T_MAX); write_reg(gsa_pkg::REG_WIN_END, 48'd0);
          write_reg(gsa_pkg::REG_DT_CORR, 48'd1); write_reg(gsa_pkg::REG_TICK_LEN, 48'd65536);
        end
        default: begin
          write_reg(gsa_pkg::REG_WIN_START, rand48() >> 18);
          write_reg(gsa_pkg::REG_WIN_END, rand48() >> 15);
          write_reg(gsa_pkg::REG_DT_CORR, {47'd0, 1'($urandom)});
          write_reg(gsa_pkg::REG_TICK_LEN, {16'd0, 32'($urandom)});
        end
      endcase
      ev = ph == 1 ? 48'h0000_3000_0000 : 48'($urandom_range(0, 1 << 20));
      repeat (60) begin
        b = int'($urandom_range(0, 3));
        ev = ev + 48'($urandom_range(0, 1 << 24));
        if ($urandom_range(0, 9) < 8) begin
          send_record(b, $urandom_range(0, 15) == 0 ? rand48() : ev, 3'($urandom),
                      8'($urandom), 8'($urandom_range(1, 255)), 16'($urandom));
        end else begin
          // Noise: reads, drops and arbitrary words.
          w = word_t'(WORD_W'({$urandom, $urandom, $urandom, $urandom}));
          if ($urandom_range(0, 1)) w.opcode = gsa_pkg::OP_READ;
          send_word(w, accumulate(w));
        end
      end
      drain();
    end

    if (errors == 0 && pending_results.size() == 0) begin
      $display("gated_spectrum_accumulator test passed");
    end else begin
      $display("gated_spectrum_accumulator test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
